// File: design/mbfr_pkg.sv
// Package for the Modbus-style frame receiver.
// Holds payload structs, command and event codes, and frame length constants.
// No dependencies.
package mbfr_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 64;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS  = 1'd1;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd500;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [7:0] CMD_RD_REGS    = 8'h03;
   localparam logic [7:0] CMD_WR_REGS    = 8'h10;
   localparam logic [7:0] CMD_SET_ADDR   = 8'h30;
   localparam logic [7:0] CMD_RD_ADDR    = 8'h31;
   localparam logic [7:0] BROADCAST_ADDR = 8'hff;

   localparam logic [7:0] CMD_BYTE_POS       = 8'd2;
   localparam logic [7:0] READ_FRAME_LEN     = 8'd8;
   localparam logic [7:0] SET_ADDR_FRAME_LEN = 8'd6;
   localparam logic [7:0] WRITE_HEADER_LEN   = 8'd7;
   localparam logic [7:0] CRC_LEN            = 8'd2;

   localparam logic [1:0] KIND_READ      = 2'd0;
   localparam logic [1:0] KIND_WRITE     = 2'd1;
   localparam logic [1:0] KIND_SET_ADDR  = 2'd2;
   localparam logic [1:0] KIND_READ_ADDR = 2'd3;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_DONE     = 3'd1;
   localparam logic [2:0] EV_OVERSIZE = 3'd2;
   localparam logic [2:0] EV_REJECT   = 3'd3;
   localparam logic [2:0] EV_TIMEOUT  = 3'd4;

   typedef struct packed {
      logic [0:0] opcode;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [1:0] command_kind;
      logic [6:0] frame_length;
      logic [0:0] byte_stored;
      logic [5:0] byte_position;
      logic [7:0] data_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

// File: design/modbus_like_frame_receiver_top.sv
// Top level of the Modbus-style request frame receiver.
// Depends on mbfr_pkg, mbfr_csr and mbfr_frame_ctl.
//
// Usage:
//   req channel (valid/ready) carries one item per serial byte or per
//   one-millisecond tick. rsp channel (valid/ready) returns exactly one item
//   per request item, in order: the frame event, the command kind, the frame
//   length, and the echoed byte with its position in the frame.
//   csr port writes device_address (index 0) and timeout_ticks (index 1);
//   write only while no item is in flight.
// Path: the input register takes the req item, the result register drives
//   rsp_valid. Throughput: one item per cycle while rsp_ready is high.
//   The decision in between is one pass of compares and a counter update.
// Reset: synchronous; clears the frame state and both stages, and loads
//   device_address 1 and timeout_ticks 500.
// Stall: when rsp_ready is low the result register holds its item; the input
//   register still takes one more item, then req_ready drops until the
//   result is taken.
module modbus_like_frame_receiver_top #(
   parameter int unsigned MAX_FRAME_BYTES = mbfr_pkg::MAX_FRAME_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mbfr_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mbfr_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_write_enable,
   input  logic [mbfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbfr_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic                      in_valid_ff;
   mbfr_pkg::req_payload_type in_item_ff;
   logic                      out_valid_ff;
   mbfr_pkg::rsp_payload_type out_item_ff;

   logic                      advance;
   mbfr_pkg::cfg_type         cfg;
   mbfr_pkg::rsp_payload_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   mbfr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mbfr_frame_ctl #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_ctl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule

// File: design/mbfr_csr.sv
// Configuration registers of the frame receiver: device address and timeout.
// Depends on mbfr_pkg.
module mbfr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mbfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mbfr_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output mbfr_pkg::cfg_type                    cfg
);

   mbfr_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= mbfr_pkg::DEVICE_ADDRESS_RESET;
         cfg_ff.timeout_ticks  <= mbfr_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mbfr_pkg::CSR_DEVICE_ADDRESS: cfg_ff.device_address <= csr_write_data[7:0];
            mbfr_pkg::CSR_TIMEOUT_TICKS:  cfg_ff.timeout_ticks  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/mbfr_frame_ctl.sv
// Frame tracking state and the per-item decision logic.
// Depends on mbfr_pkg.
module mbfr_frame_ctl #(
   parameter int unsigned MAX_FRAME_BYTES = mbfr_pkg::MAX_FRAME_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  mbfr_pkg::req_payload_type item,
   input  mbfr_pkg::cfg_type         cfg,
   output mbfr_pkg::rsp_payload_type result
);

   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  previous_byte_ff, previous_byte_in;
   logic        in_frame_ff, in_frame_in;
   logic [1:0]  command_held_ff, command_held_in;
   logic [7:0]  write_byte_count_ff, write_byte_count_in;
   logic [15:0] elapsed_ticks_ff, elapsed_ticks_in;

   logic [7:0]  count_inc;
   logic [15:0] elapsed_sat;
   logic [8:0]  write_end;
   logic [8:0]  write_end_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff       <= '0;
         previous_byte_ff    <= '0;
         in_frame_ff         <= 1'b0;
         command_held_ff     <= '0;
         write_byte_count_ff <= '0;
         elapsed_ticks_ff    <= '0;
      end else if (step) begin
         byte_count_ff       <= byte_count_in;
         previous_byte_ff    <= previous_byte_in;
         in_frame_ff         <= in_frame_in;
         command_held_ff     <= command_held_in;
         write_byte_count_ff <= write_byte_count_in;
         elapsed_ticks_ff    <= elapsed_ticks_in;
      end
   end

   always_comb begin
      byte_count_in       = byte_count_ff;
      previous_byte_in    = previous_byte_ff;
      in_frame_in         = in_frame_ff;
      command_held_in     = command_held_ff;
      write_byte_count_in = write_byte_count_ff;
      elapsed_ticks_in    = elapsed_ticks_ff;
      result              = '0;

      count_inc     = byte_count_ff + 8'd1;
      elapsed_sat   = (elapsed_ticks_ff != 16'hffff) ? elapsed_ticks_ff + 16'd1
                                                     : elapsed_ticks_ff;
      write_end     = {1'b0, write_byte_count_ff}
                      + {1'b0, mbfr_pkg::WRITE_HEADER_LEN} + {1'b0, mbfr_pkg::CRC_LEN};
      write_end_new = {1'b0, item.rx_byte}
                      + {1'b0, mbfr_pkg::WRITE_HEADER_LEN} + {1'b0, mbfr_pkg::CRC_LEN};

      if (item.opcode == mbfr_pkg::OP_TICK) begin
         if (byte_count_ff != 8'd0) begin
            elapsed_ticks_in = elapsed_sat;
            if (elapsed_sat >= cfg.timeout_ticks) begin
               byte_count_in    = '0;
               in_frame_in      = 1'b0;
               result.event_res = mbfr_pkg::EV_TIMEOUT;
            end
         end
      end else begin
         if (byte_count_ff == 8'd0) begin
            elapsed_ticks_in = '0;
         end
         result.byte_stored   = 1'b1;
         result.byte_position = byte_count_ff[5:0];
         result.data_byte     = item.rx_byte;
         byte_count_in        = count_inc;
         previous_byte_in     = item.rx_byte;

         if (in_frame_ff) begin
            case (command_held_ff)
               mbfr_pkg::KIND_READ: begin
                  if (count_inc == mbfr_pkg::READ_FRAME_LEN) begin
                     result.event_res    = mbfr_pkg::EV_DONE;
                     result.command_kind = mbfr_pkg::KIND_READ;
                     result.frame_length = count_inc[6:0];
                     byte_count_in       = '0;
                     in_frame_in         = 1'b0;
                  end
               end
               mbfr_pkg::KIND_WRITE: begin
                  if (count_inc == mbfr_pkg::WRITE_HEADER_LEN) begin
                     write_byte_count_in = item.rx_byte;
                     if (write_end_new > 9'(MAX_FRAME_BYTES)) begin
                        result.event_res    = mbfr_pkg::EV_OVERSIZE;
                        result.command_kind = mbfr_pkg::KIND_WRITE;
                        byte_count_in       = '0;
                        in_frame_in         = 1'b0;
                     end
                  end else if (count_inc > mbfr_pkg::WRITE_HEADER_LEN &&
                               {1'b0, count_inc} == write_end) begin
                     result.event_res    = mbfr_pkg::EV_DONE;
                     result.command_kind = mbfr_pkg::KIND_WRITE;
                     result.frame_length = count_inc[6:0];
                     byte_count_in       = '0;
                     in_frame_in         = 1'b0;
                  end
               end
               mbfr_pkg::KIND_SET_ADDR: begin
                  if (count_inc == mbfr_pkg::SET_ADDR_FRAME_LEN) begin
                     result.event_res    = mbfr_pkg::EV_DONE;
                     result.command_kind = mbfr_pkg::KIND_SET_ADDR;
                     result.frame_length = count_inc[6:0];
                     byte_count_in       = '0;
                     in_frame_in         = 1'b0;
                  end
               end
               default: begin
                  result.event_res = mbfr_pkg::EV_REJECT;
                  byte_count_in    = '0;
                  in_frame_in      = 1'b0;
               end
            endcase
         end else if (count_inc == mbfr_pkg::CMD_BYTE_POS) begin
            if (item.rx_byte == mbfr_pkg::CMD_RD_REGS ||
                item.rx_byte == mbfr_pkg::CMD_WR_REGS) begin
               if (previous_byte_ff == cfg.device_address) begin
                  in_frame_in     = 1'b1;
                  command_held_in = (item.rx_byte == mbfr_pkg::CMD_RD_REGS)
                                    ? mbfr_pkg::KIND_READ : mbfr_pkg::KIND_WRITE;
               end else begin
                  result.event_res = mbfr_pkg::EV_REJECT;
                  byte_count_in    = '0;
                  in_frame_in      = 1'b0;
               end
            end else if (item.rx_byte == mbfr_pkg::CMD_RD_ADDR &&
                         previous_byte_ff == mbfr_pkg::BROADCAST_ADDR) begin
               result.event_res    = mbfr_pkg::EV_DONE;
               result.command_kind = mbfr_pkg::KIND_READ_ADDR;
               result.frame_length = mbfr_pkg::CMD_BYTE_POS[6:0];
               byte_count_in       = '0;
               in_frame_in         = 1'b0;
            end else if (item.rx_byte == mbfr_pkg::CMD_SET_ADDR &&
                         previous_byte_ff == mbfr_pkg::BROADCAST_ADDR) begin
               in_frame_in     = 1'b1;
               command_held_in = mbfr_pkg::KIND_SET_ADDR;
            end else begin
               result.event_res = mbfr_pkg::EV_REJECT;
               byte_count_in    = '0;
               in_frame_in      = 1'b0;
            end
         end else if (count_inc > mbfr_pkg::CMD_BYTE_POS) begin
            result.event_res = mbfr_pkg::EV_REJECT;
            byte_count_in    = '0;
            in_frame_in      = 1'b0;
         end
      end
   end

endmodule

// File: dv/tb_modbus_like_frame_receiver_top.sv
// Self-checking testbench for modbus_like_frame_receiver_top: drives bytes and ticks,
// predicts every frame event and byte echo in a scoreboard class, checks each result.
// Depends on mbfr_pkg and the RTL of the block only.
module tb_modbus_like_frame_receiver_top;
   import mbfr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 240;

   class frame_event_tracker;
      logic [7:0]      dev_addr;
      logic [15:0]     timeout_limit;
      logic [7:0]      count;
      logic [7:0]      prev_byte;
      logic [7:0]      write_len;
      logic [1:0]      kind_held;
      logic [15:0]     ticks_seen;
      bit              in_frame;
      rsp_payload_type awaited[$];
      int              errors;
      int              event_tally[5];

      function new();
         dev_addr      = DEVICE_ADDRESS_RESET;
         timeout_limit = TIMEOUT_TICKS_RESET;
         count         = '0;
         prev_byte     = '0;
         write_len     = '0;
         kind_held     = KIND_READ;
         ticks_seen    = '0;
         in_frame      = 1'b0;
         errors        = 0;
         foreach (event_tally[i]) event_tally[i] = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_DEVICE_ADDRESS) dev_addr = value[7:0];
         else timeout_limit = value[15:0];
      endfunction

      function void drop_frame();
         count    = '0;
         in_frame = 1'b0;
      endfunction

      function void note_item(req_payload_type item);
         rsp_payload_type r;
         logic [7:0]      b;
         r = '0;
         b = item.rx_byte;
         if (item.opcode == OP_TICK) begin
            if (count != 0) begin
               if (ticks_seen != 16'hffff) ticks_seen = ticks_seen + 16'd1;
               if (ticks_seen >= timeout_limit) begin
                  drop_frame();
                  r.event_res = EV_TIMEOUT;
               end
            end
         end else begin
            if (count == 0) ticks_seen = '0;
            r.byte_stored   = 1'b1;
            r.byte_position = count[5:0];
            r.data_byte     = b;
            count = count + 8'd1;
            if (in_frame) begin
               case (kind_held)
                  KIND_READ: if (count == READ_FRAME_LEN) begin
                     r.event_res    = EV_DONE;
                     r.command_kind = KIND_READ;
                     r.frame_length = count[6:0];
                     drop_frame();
                  end
                  KIND_WRITE: if (count == WRITE_HEADER_LEN) begin
                     write_len = b;
                     if (int'(b) + int'(WRITE_HEADER_LEN) + int'(CRC_LEN) > MAX_FRAME_BYTES) begin
                        r.event_res    = EV_OVERSIZE;
                        r.command_kind = KIND_WRITE;
                        drop_frame();
                     end
                  end else if (count > WRITE_HEADER_LEN && int'(count) ==
                               int'(write_len) + int'(WRITE_HEADER_LEN) + int'(CRC_LEN)) begin
                     r.event_res    = EV_DONE;
                     r.command_kind = KIND_WRITE;
                     r.frame_length = count[6:0];
                     drop_frame();
                  end
                  KIND_SET_ADDR: if (count == SET_ADDR_FRAME_LEN) begin
                     r.event_res    = EV_DONE;
                     r.command_kind = KIND_SET_ADDR;
                     r.frame_length = count[6:0];
                     drop_frame();
                  end
                  default: begin
                     drop_frame();
                     r.event_res = EV_REJECT;
                  end
               endcase
            end else if (count == CMD_BYTE_POS) begin
               if (b == CMD_RD_REGS || b == CMD_WR_REGS) begin
                  if (prev_byte == dev_addr) begin
                     in_frame  = 1'b1;
                     kind_held = (b == CMD_RD_REGS) ? KIND_READ : KIND_WRITE;
                  end else begin
                     drop_frame();
                     r.event_res = EV_REJECT;
                  end
               end else if (b == CMD_RD_ADDR && prev_byte == BROADCAST_ADDR) begin
                  r.event_res    = EV_DONE;
                  r.command_kind = KIND_READ_ADDR;
                  r.frame_length = count[6:0];
                  drop_frame();
               end else if (b == CMD_SET_ADDR && prev_byte == BROADCAST_ADDR) begin
                  in_frame  = 1'b1;
                  kind_held = KIND_SET_ADDR;
               end else begin
                  drop_frame();
                  r.event_res = EV_REJECT;
               end
            end else if (count > CMD_BYTE_POS) begin
               drop_frame();
               r.event_res = EV_REJECT;
            end
            prev_byte = b;
         end
         event_tally[r.event_res]++;
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare_field("event_res", 8'(want.event_res), 8'(got.event_res));
         compare_field("command_kind", 8'(want.command_kind), 8'(got.command_kind));
         compare_field("frame_length", 8'(want.frame_length), 8'(got.frame_length));
         compare_field("byte_stored", 8'(want.byte_stored), 8'(got.byte_stored));
         compare_field("byte_position", 8'(want.byte_position), 8'(got.byte_position));
         compare_field("data_byte", want.data_byte, got.data_byte);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   frame_event_tracker tracker;
   int cycle_count;
   int items_sent;
   int phase_goal;
   int burst_left;
   int settings_used;
   int tick_odds;
   bit sender_idling;

   modbus_like_frame_receiver_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modbus_like_frame_receiver_top verification failed");
         $finish;
      end
   end

   // receiver: rotates through always-ready, random, periodic and long-stall patterns
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
      case ((cycle_count / 300) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (cycle_count % 4 != 3);
         default: rsp_ready <= (cycle_count % 16 >= 5);
      endcase
   end

   task automatic send_item(req_payload_type item);
      int gap;
      if (sender_idling) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(item);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      req_payload_type item;
      item.opcode  = OP_BYTE;
      item.rx_byte = b;
      send_item(item);
   endtask

   task automatic send_tick();
      req_payload_type item;
      item.opcode  = OP_TICK;
      item.rx_byte = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   task automatic send_body(int n);
      repeat (n) begin
         if ($urandom_range(0, tick_odds) == 0) send_tick();
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_write_frame(logic [7:0] count_byte);
      send_byte(tracker.dev_addr);
      send_byte(CMD_WR_REGS);
      send_body(4);
      send_byte(count_byte);
      if (int'(count_byte) + int'(WRITE_HEADER_LEN) + int'(CRC_LEN) <= MAX_FRAME_BYTES)
         send_body(int'(count_byte) + int'(CRC_LEN));
   endtask

   task automatic send_set_addr_frame();
      send_byte(BROADCAST_ADDR);
      send_byte(CMD_SET_ADDR);
      send_body(4);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_settings(logic [7:0] addr, logic [15:0] limit);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEVICE_ADDRESS;
      csr_write_data   <= {junk, addr};
      @(posedge clock);
      tracker.set_register(CSR_DEVICE_ADDRESS, {junk, addr});
      csr_index      <= CSR_TIMEOUT_TICKS;
      csr_write_data <= limit;
      @(posedge clock);
      tracker.set_register(CSR_TIMEOUT_TICKS, limit);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic send_sequence();
      int         pick;
      int         n;
      logic [7:0] a;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_byte(tracker.dev_addr);
         send_byte(CMD_RD_REGS);
         send_body(6);
      end else if (pick < 40) begin
         n = $urandom_range(0, 19);
         if (n < 13) send_write_frame(8'($urandom_range(0, 8)));
         else if (n < 16) send_write_frame(8'($urandom_range(9, 54)));
         else if (n == 16) send_write_frame(8'd55);
         else if (n == 17) send_write_frame(8'd56);
         else send_write_frame(8'($urandom_range(57, 255)));
      end else if (pick < 50) begin
         send_set_addr_frame();
      end else if (pick < 58) begin
         send_byte(BROADCAST_ADDR);
         send_byte(CMD_RD_ADDR);
      end else if (pick < 66) begin
         do a = 8'($urandom_range(0, 255)); while (a == tracker.dev_addr);
         send_byte(a);
         send_byte($urandom_range(0, 1) ? CMD_RD_REGS : CMD_WR_REGS);
      end else if (pick < 74) begin
         send_byte(8'($urandom_range(0, 255)));
         send_byte(8'($urandom_range(0, 255)));
         send_body($urandom_range(0, 2));
      end else if (pick < 86) begin
         // frame start left to expire (it may also complete or be rejected), sometimes one tick short
         n = $urandom_range(1, 6);
         send_byte($urandom_range(0, 1) ? tracker.dev_addr : BROADCAST_ADDR);
         if (n > 1) begin
            case ($urandom_range(0, 2))
               0: c = CMD_RD_REGS;
               1: c = CMD_WR_REGS;
               default: c = CMD_SET_ADDR;
            endcase
            send_byte(c);
            repeat (n - 2) send_byte(8'($urandom_range(0, 255)));
         end
         if (tracker.timeout_limit <= 64) n = int'(tracker.timeout_limit) + $urandom_range(0, 3) - 1;
         else n = $urandom_range(1, 30);
         if (n < 1) n = 1;
         repeat (n) send_tick();
      end else begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1)) send_tick();
            else send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic run_phase(logic [7:0] addr, logic [15:0] limit, bit idle);
      drain();
      apply_settings(addr, limit);
      sender_idling = idle;
      burst_left    = 0;
      tick_odds     = (limit < 64) ? 40 : 6;
      phase_goal += PHASE_ITEMS;
      while (items_sent < phase_goal) send_sequence();
   endtask

   initial begin
      tracker = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      rsp_ready        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      sender_idling = 1'b1;
      burst_left    = 0;
      tick_odds     = 6;

      // directed: write, read-address and set-address frames and two reject paths at reset settings
      send_write_frame(8'd0);
      send_byte(BROADCAST_ADDR);
      send_byte(CMD_RD_ADDR);
      send_set_addr_frame();
      send_byte(8'h00);
      send_byte(CMD_RD_REGS);
      send_byte(BROADCAST_ADDR);
      send_byte(BROADCAST_ADDR);
      send_tick();

      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) send_sequence();
      run_phase(8'h00, 16'd1, 1'b1);
      run_phase(8'hff, 16'hffff, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 16'd0, 1'b1);
      run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(2, 12)), 1'b1);
      run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(13, 64)), 1'b0);
      run_phase(DEVICE_ADDRESS_RESET, 16'($urandom_range(0, 65535)), 1'b1);
      drain();

      $display("Run covered %0d items over %0d register settings with gaps and stalls.",
               items_sent, settings_used);
      $display("Events: %0d frames, %0d oversize, %0d rejects, %0d timeouts.",
               tracker.event_tally[EV_DONE], tracker.event_tally[EV_OVERSIZE],
               tracker.event_tally[EV_REJECT], tracker.event_tally[EV_TIMEOUT]);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("modbus_like_frame_receiver_top verification clean");
      else
         $display("modbus_like_frame_receiver_top verification failed");
      $finish;
   end
endmodule

// File: modbus_like_frame_receiver_top.f
design/mbfr_pkg.sv
design/mbfr_csr.sv
design/mbfr_frame_ctl.sv
design/modbus_like_frame_receiver_top.sv
dv/tb_modbus_like_frame_receiver_top.sv
